### sv/chms_pkg.sv
// Package for the cache hit/miss simulator.
// Holds the transaction and configuration types and fixed codes.
// Used by chms_addr_split and the top level.
package chms_pkg;

	typedef struct packed {
		logic        opcode;
		logic [31:0] address;
	} chms_req_t;

	typedef struct packed {
		logic        hit;
		logic [10:0] cycles;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} chms_rsp_t;

	typedef struct packed {
		logic       mapping_mode;
		logic [1:0] replace_policy;
		logic [3:0] offset_bits;
		logic [2:0] index_bits;
		logic [7:0] hit_time;
		logic [9:0] lower_level_time;
	} chms_cfg_t;

	localparam logic [2:0] CFG_MAPPING_MODE     = 3'd0;
	localparam logic [2:0] CFG_REPLACE_POLICY   = 3'd1;
	localparam logic [2:0] CFG_OFFSET_BITS      = 3'd2;
	localparam logic [2:0] CFG_INDEX_BITS       = 3'd3;
	localparam logic [2:0] CFG_HIT_TIME         = 3'd4;
	localparam logic [2:0] CFG_LOWER_LEVEL_TIME = 3'd5;

	localparam logic       MODE_DIRECT = 1'b0;
	localparam logic       OP_STORE    = 1'b1;

	localparam logic [1:0] POL_LRU  = 2'd0;
	localparam logic [1:0] POL_FIFO = 2'd1;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

endpackage

### sv/chms_addr_split.sv
// Address split for the cache hit/miss simulator.
// Derives the direct-mapped tag and index and the fully associative tag.
// Depends on chms_pkg.
module chms_addr_split (
	input  logic [31:0]       address,
	input  chms_pkg::chms_cfg_t cfg,
	output logic [31:0]       tag_dm,
	output logic [31:0]       tag_fa,
	output logic [6:0]        index
);
	import chms_pkg::*;

	logic [4:0] dm_shift;
	logic [6:0] index_mask;

	assign dm_shift   = 5'(cfg.offset_bits) + 5'(cfg.index_bits);
	assign index_mask = 7'((8'd1 << cfg.index_bits) - 8'd1);
	assign tag_fa     = address >> cfg.offset_bits;
	assign tag_dm     = address >> dm_shift;
	assign index      = tag_fa[6:0] & index_mask;

endmodule

### sv/cache_hit_miss_simulator_top.sv
// Top level of the cache hit/miss simulator.
// Sequencer, tag and rank memories, replacement state and counters.
// Depends on chms_pkg and chms_addr_split.
//
// Usage: drive req and raise start; the access is taken at a clock edge where
// start is high and busy is low. busy stays high until the result is formed.
// The result appears on rsp for exactly one cycle with done high; it cannot
// be held off. Configuration writes use cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is high while the block is idle and start is low,
// unknown indexes are dropped.
// Sequence, from acceptance to the next possible acceptance, at which the
// result is on rsp:
//   direct-mapped: the index reduction modulo LINES on a reciprocal
//   multiplier (quotient, then remainder), then a tag read and compare.
//   fully associative: a tag scan over all lines; a store miss ends there,
//   a hit or an LRU fill goes on to the rank update sweep, a FIFO fill reads
//   the victim's rank first, a pseudo-random fill reduces the LFSR value
//   modulo LINES and reads the rank first; both sweeps go one line per cycle.
// Reset clears valid bits, ranks (back to line number), FIFO pointer and
// counters and loads the LFSR seed and the default configuration at once;
// no clearing pass is needed.
module cache_hit_miss_simulator_top #(
	parameter int LINES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  chms_pkg::chms_req_t req,
	output logic                done,
	output chms_pkg::chms_rsp_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [9:0]          cfg_data
);
	import chms_pkg::*;

	localparam int LW       = $clog2(LINES);
	localparam int CW       = LW + 1;
	localparam int RECIP_SH = 16 + LW;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(LINES) - 64'd1) / 64'(LINES);
	localparam logic [16:0] RECIP = 17'(RECIP_FULL);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_MOD       = 4'd1;
	localparam logic [3:0] S_DM_RD     = 4'd2;
	localparam logic [3:0] S_DM_CMP    = 4'd3;
	localparam logic [3:0] S_SCAN      = 4'd4;
	localparam logic [3:0] S_DECIDE    = 4'd5;
	localparam logic [3:0] S_RANK_RD   = 4'd6;
	localparam logic [3:0] S_RANK_WAIT = 4'd7;
	localparam logic [3:0] S_TOUCH     = 4'd8;
	localparam logic [3:0] S_DONE      = 4'd9;
	localparam logic [3:0] S_MOD_SUB   = 4'd10;

	logic [3:0]    state_q;
	chms_cfg_t     cfg_q;
	logic          op_q;
	logic [31:0]   tag_q;
	logic [15:0]   rem_q;
	logic [15:0]   quot_q;
	logic          mod_dm_q;
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] line_q;
	logic [LW-1:0] old_q;
	logic [LW-1:0] lru_q;
	logic          found_q;
	logic          hit_q;
	logic [LW-1:0] fifo_q;
	logic [15:0]   lfsr_q;
	logic [31:0]   hit_cnt_q;
	logic [31:0]   miss_cnt_q;
	logic          done_q;
	chms_rsp_t     rsp_q;

	logic [LINES-1:0] valid_q;
	logic [LINES-1:0] rank_set_q;
	logic [31:0]      tag_mem [LINES];
	logic [LW-1:0]    rank_mem [LINES];

	logic [31:0]   tag_rd_s1;
	logic          valid_rd_s1;
	logic [LW-1:0] rank_rd_s1;
	logic          rank_set_rd_s1;
	logic [LW-1:0] idx_s1;
	logic          vld_s1;

	logic [31:0]      tag_dm;
	logic [31:0]      tag_fa;
	logic [6:0]       dm_index;
	logic [LW-1:0]    rd_addr;
	logic             sweep;
	logic             cnt_end;
	logic [LW-1:0]    rank_val;
	logic             tag_match;
	logic [32:0]      mod_prod;
	logic [15:0]      rem_mod;
	logic [15:0]      lfsr_next;
	logic             rank_we;
	logic [LW-1:0]    rank_wdata;
	logic             fill;
	logic             charge_lower;
	logic [31:0]      hit_cnt_next;
	logic [31:0]      miss_cnt_next;

	chms_addr_split u_addr_split (
		.address (req.address),
		.cfg     (cfg_q),
		.tag_dm  (tag_dm),
		.tag_fa  (tag_fa),
		.index   (dm_index)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy && !start;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign sweep    = (state_q == S_SCAN) || (state_q == S_TOUCH);
	assign cnt_end  = (cnt_q == CW'(LINES));
	assign rd_addr  = sweep ? cnt_q[LW-1:0] : line_q;
	assign rank_val = rank_set_rd_s1 ? rank_rd_s1 : idx_s1;
	assign tag_match = valid_rd_s1 && (tag_rd_s1 == tag_q);

	assign mod_prod = 33'(rem_q) * 33'(RECIP);
	assign rem_mod  = rem_q - 16'(32'(quot_q) * 32'(LINES));

	assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	assign rank_we    = (state_q == S_TOUCH) && vld_s1;
	assign rank_wdata = (idx_s1 == line_q) ? LW'(LINES - 1) :
		((rank_val > old_q) ? rank_val - LW'(1) : rank_val);

	assign fill          = (state_q == S_DONE) && !hit_q && (op_q != OP_STORE);
	assign charge_lower  = (hit_q == (op_q == OP_STORE));
	assign hit_cnt_next  = hit_cnt_q + 32'(hit_q);
	assign miss_cnt_next = miss_cnt_q + 32'(!hit_q);

	always_ff @(posedge clk) begin
		tag_rd_s1  <= tag_mem[rd_addr];
		rank_rd_s1 <= rank_mem[rd_addr];
		if (fill) begin
			tag_mem[line_q] <= tag_q;
		end
		if (rank_we) begin
			rank_mem[idx_s1] <= rank_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			rank_set_q     <= '0;
			valid_rd_s1    <= 1'b0;
			rank_set_rd_s1 <= 1'b0;
			idx_s1         <= '0;
			vld_s1         <= 1'b0;
		end else begin
			valid_rd_s1    <= valid_q[rd_addr];
			rank_set_rd_s1 <= rank_set_q[rd_addr];
			idx_s1         <= rd_addr;
			vld_s1         <= sweep && !cnt_end;
			if (fill) begin
				valid_q[line_q] <= 1'b1;
			end
			if (rank_we) begin
				rank_set_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapping_mode     <= 1'b0;
			cfg_q.replace_policy   <= 2'd0;
			cfg_q.offset_bits      <= 4'd2;
			cfg_q.index_bits       <= 3'd6;
			cfg_q.hit_time         <= 8'd1;
			cfg_q.lower_level_time <= 10'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAPPING_MODE:     cfg_q.mapping_mode     <= cfg_data[0];
				CFG_REPLACE_POLICY:   cfg_q.replace_policy   <= cfg_data[1:0];
				CFG_OFFSET_BITS:      cfg_q.offset_bits      <= cfg_data[3:0];
				CFG_INDEX_BITS:       cfg_q.index_bits       <= cfg_data[2:0];
				CFG_HIT_TIME:         cfg_q.hit_time         <= cfg_data[7:0];
				CFG_LOWER_LEVEL_TIME: cfg_q.lower_level_time <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= 1'b0;
			tag_q      <= '0;
			rem_q      <= '0;
			quot_q     <= '0;
			mod_dm_q   <= 1'b0;
			cnt_q      <= '0;
			line_q     <= '0;
			old_q      <= '0;
			lru_q      <= '0;
			found_q    <= 1'b0;
			hit_q      <= 1'b0;
			fifo_q     <= '0;
			lfsr_q     <= LFSR_SEED;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (sweep && !cnt_end) begin
				cnt_q <= cnt_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= req.opcode;
						found_q <= 1'b0;
						cnt_q   <= '0;
						if (cfg_q.mapping_mode == MODE_DIRECT) begin
							tag_q    <= tag_dm;
							rem_q    <= 16'(dm_index);
							mod_dm_q <= 1'b1;
							state_q  <= S_MOD;
						end else begin
							tag_q   <= tag_fa;
							state_q <= S_SCAN;
						end
					end
				end
				S_MOD: begin
					quot_q  <= 16'(mod_prod >> RECIP_SH);
					state_q <= S_MOD_SUB;
				end
				S_MOD_SUB: begin
					line_q  <= rem_mod[LW-1:0];
					state_q <= mod_dm_q ? S_DM_RD : S_RANK_RD;
				end
				S_DM_RD: begin
					state_q <= S_DM_CMP;
				end
				S_DM_CMP: begin
					hit_q   <= tag_match;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (vld_s1) begin
						if (tag_match && !found_q) begin
							found_q <= 1'b1;
							line_q  <= idx_s1;
							old_q   <= rank_val;
						end
						if (rank_val == '0) begin
							lru_q <= idx_s1;
						end
					end
					if (cnt_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					hit_q <= found_q;
					cnt_q <= '0;
					if (found_q) begin
						state_q <= S_TOUCH;
					end else if (op_q == OP_STORE) begin
						state_q <= S_DONE;
					end else begin
						case (cfg_q.replace_policy)
							POL_LRU: begin
								line_q  <= lru_q;
								old_q   <= '0;
								state_q <= S_TOUCH;
							end
							POL_FIFO: begin
								line_q  <= fifo_q;
								fifo_q  <= (fifo_q == LW'(LINES - 1)) ? '0 : fifo_q + LW'(1);
								state_q <= S_RANK_RD;
							end
							default: begin
								lfsr_q   <= lfsr_next;
								rem_q    <= lfsr_next;
								mod_dm_q <= 1'b0;
								state_q  <= S_MOD;
							end
						endcase
					end
				end
				S_RANK_RD: begin
					state_q <= S_RANK_WAIT;
				end
				S_RANK_WAIT: begin
					old_q   <= rank_val;
					cnt_q   <= '0;
					state_q <= S_TOUCH;
				end
				S_TOUCH: begin
					if (cnt_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					hit_cnt_q        <= hit_cnt_next;
					miss_cnt_q       <= miss_cnt_next;
					rsp_q.hit        <= hit_q;
					rsp_q.cycles     <= 11'(cfg_q.hit_time) +
						(charge_lower ? 11'(cfg_q.lower_level_time) : 11'd0);
					rsp_q.hit_total  <= hit_cnt_next;
					rsp_q.miss_total <= miss_cnt_next;
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/chms_checker.sv
// Port-level checker for the cache hit/miss simulator.
// Watches the start/busy/done sequence over time; bound to the top level.
// Depends on the port list of cache_hit_miss_simulator_top.
module chms_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted transaction");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy && !start)
		else $error("configuration ready while a transaction is in flight");

endmodule

bind cache_hit_miss_simulator_top chms_checker u_chms_checker (.*);
